@@ hw/rtl/ser_pkg.sv @@
// Shared types and constants for the sonar echo ranger.
// Holds the request and result structs, the register map and the distance scale.
// No dependencies.
`default_nettype none

package ser_pkg;

	// register map of the configuration port
	typedef enum logic [1:0] {
		REG_ENABLE         = 2'd0,
		REG_TRIGGER_PERIOD = 2'd1,
		REG_ECHO_TIMEOUT   = 2'd2,
		REG_TRIGGER_WIDTH  = 2'd3
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 20;

	// register reset values
	localparam logic [19:0] PERIOD_RESET  = 20'd40000;
	localparam logic [15:0] TIMEOUT_RESET = 16'd25000;
	localparam logic [7:0]  TRIG_W_RESET  = 8'd10;

	// saturation limits of the tick and width counters
	localparam logic [19:0] SINCE_MAX = 20'hFFFFF;
	localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

	// distance = floor(width*8/29); x/29 as (x*DIST_RECIP) >> DIST_SHIFT,
	// exact for x < 2^19 since DIST_RECIP*29 - 2^24 = 9
	localparam int unsigned DIST_SHIFT = 24;
	localparam logic [19:0] DIST_RECIP = 20'd578525;

	typedef struct packed {
		logic enable;
		logic [19:0] trigger_period_us;
		logic [15:0] echo_timeout_us;
		logic [7:0]  trigger_width_us;
	} cfg_t;

	typedef struct packed {
		logic echo_level;
		logic clear_counters;
	} item_t;

	typedef struct packed {
		logic trigger_out;
		logic sample_done;
		logic sample_valid;
		logic missed;
		logic [15:0] pulse_width_us;
		logic [14:0] distance_sixteenth_cm;
		logic [31:0] ping_total;
		logic [31:0] valid_total;
		logic [31:0] timeout_total;
		logic [31:0] miss_total;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/ser_cfg.sv @@
// Configuration registers of the sonar echo ranger.
// Plain write port decoded by register index; depends on ser_pkg.
`default_nettype none

module ser_cfg (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  ser_pkg::cfg_index_t            cfg_index,
	input  wire [ser_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ser_pkg::cfg_t                  cfg
);
	import ser_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.trigger_period_us <= PERIOD_RESET;
			cfg_q.echo_timeout_us   <= TIMEOUT_RESET;
			cfg_q.trigger_width_us  <= TRIG_W_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE:         cfg_q.enable            <= cfg_data[0];
				REG_TRIGGER_PERIOD: cfg_q.trigger_period_us <= cfg_data[19:0];
				REG_ECHO_TIMEOUT:   cfg_q.echo_timeout_us   <= cfg_data[15:0];
				REG_TRIGGER_WIDTH:  cfg_q.trigger_width_us  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/ser_core.sv @@
// Per-tick ranging state: trigger timing, echo edge capture, width, counters.
// Computes one tick's result from the registered request; depends on ser_pkg.
`default_nettype none

module ser_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              step,
	input  ser_pkg::item_t   item,
	input  ser_pkg::cfg_t    cfg,
	output ser_pkg::result_t result
);
	import ser_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_FALL  = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [19:0] since_q, since_d;
	logic [15:0] width_q, width_d;
	logic        prev_q;
	logic [7:0]  tleft_q, tleft_d;
	logic [15:0] last_q, last_d;
	logic [31:0] pings_q, pings_d;
	logic [31:0] valids_q, valids_d;
	logic [31:0] touts_q, touts_d;
	logic [31:0] misses_q, misses_d;

	logic        miss, done, valid, trig;
	logic [18:0] dist_num;
	logic [38:0] dist_prod;

	// one tick of the ranging sequence
	always_comb begin
		phase_d  = phase_q;
		width_d  = width_q;
		tleft_d  = tleft_q;
		last_d   = last_q;
		miss     = 1'b0;
		done     = 1'b0;
		valid    = 1'b0;
		trig     = 1'b0;

		// counter clear happens before this tick's events
		pings_d  = item.clear_counters ? '0 : pings_q;
		valids_d = item.clear_counters ? '0 : valids_q;
		touts_d  = item.clear_counters ? '0 : touts_q;
		misses_d = item.clear_counters ? '0 : misses_q;

		since_d = (since_q != SINCE_MAX) ? since_q + 20'd1 : since_q;

		// pending echo too old: miss wins over any edge this tick
		if (phase_q != PH_IDLE && since_d > {4'd0, cfg.echo_timeout_us}) begin
			phase_d  = PH_IDLE;
			miss     = 1'b1;
			misses_d = misses_d + 32'd1;
			touts_d  = touts_d + 32'd1;
		end else begin
			unique case (phase_q)
				PH_ARMED: begin
					if (item.echo_level && !prev_q) begin
						width_d = 16'd1;
						phase_d = PH_FALL;
					end
				end
				PH_FALL: begin
					if (item.echo_level) begin
						if (width_q != WIDTH_MAX)
							width_d = width_q + 16'd1;
					end else begin
						last_d  = width_q;
						done    = 1'b1;
						phase_d = PH_IDLE;
						if (width_q == 16'd0 || width_q >= cfg.echo_timeout_us) begin
							touts_d = touts_d + 32'd1;
						end else begin
							valid    = 1'b1;
							valids_d = valids_d + 32'd1;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		// trigger start
		if (cfg.enable && phase_d == PH_IDLE && since_d >= cfg.trigger_period_us) begin
			since_d = '0;
			phase_d = PH_ARMED;
			width_d = '0;
			tleft_d = cfg.trigger_width_us;
			pings_d = pings_d + 32'd1;
		end

		// trigger output
		if (tleft_d != 8'd0) begin
			trig    = 1'b1;
			tleft_d = tleft_d - 8'd1;
		end
	end

	// distance: floor(width*8/29) by reciprocal multiply
	assign dist_num  = {width_q, 3'b000};
	assign dist_prod = {20'd0, dist_num} * {19'd0, DIST_RECIP};

	always_comb begin
		result.trigger_out           = trig;
		result.sample_done           = done;
		result.sample_valid          = valid;
		result.missed                = miss;
		result.pulse_width_us        = last_d;
		result.distance_sixteenth_cm = valid ? dist_prod[DIST_SHIFT +: 15] : 15'd0;
		result.ping_total            = pings_d;
		result.valid_total           = valids_d;
		result.timeout_total         = touts_d;
		result.miss_total            = misses_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			since_q  <= '0;
			width_q  <= '0;
			prev_q   <= 1'b0;
			tleft_q  <= '0;
			last_q   <= '0;
			pings_q  <= '0;
			valids_q <= '0;
			touts_q  <= '0;
			misses_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			since_q  <= since_d;
			width_q  <= width_d;
			prev_q   <= item.echo_level;
			tleft_q  <= tleft_d;
			last_q   <= last_d;
			pings_q  <= pings_d;
			valids_q <= valids_d;
			touts_q  <= touts_d;
			misses_q <= misses_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sonar_echo_ranger.sv @@
// Top level of the sonar echo ranger: request register, ranging core, result register.
// Depends on ser_pkg, ser_cfg and ser_core.
`default_nettype none

// Each request is one microsecond tick carrying the sampled echo level and a
// counter clear; each gives exactly one result. The block takes one request
// every clock cycle while the result is not stalled; its result passes the
// request register, then the result register. The rate is set by the
// per-tick state update in ser_core. A stalled result is held while one more request
// waits in the request register. Configuration must be written through cfg_write,
// cfg_index, cfg_data only while no request is in flight; the block does not enforce it.
module sonar_echo_ranger (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  ser_pkg::cfg_index_t            cfg_index,
	input  wire [ser_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                            item_valid,
	output logic                           item_stall,
	input  ser_pkg::item_t                 item,
	output logic                           result_valid,
	input  wire                            result_stall,
	output ser_pkg::result_t               result
);
	import ser_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t core_result;
	result_t result_q;
	logic    result_valid_q;

	ser_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// process the held request when the result slot is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	ser_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= core_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
